/* design/rhc_pkg.sv */
// Package for the RGB to HSL converter: field widths, pipeline widths,
// the hue sector code and the record passed from the front end to the dividers.
// No dependencies.
package rhc_pkg;

    localparam int CH_W   = 8;   // one color channel or alpha
    localparam int HUE_W  = 13;  // hue in 1/16 degree
    localparam int PCT_W  = 14;  // saturation and lightness in 1/128 percent
    localparam int NUM_W  = 23;  // dividend width of both divisions
    localparam int DEN_W  = 9;   // divisor width of both divisions
    localparam int QUO_W  = 14;  // quotient bits produced by each divider

    localparam logic [QUO_W-1:0] HUE_TURN = QUO_W'(5760);

    typedef logic [CH_W-1:0]  chan_t;
    typedef logic [HUE_W-1:0] hue_t;
    typedef logic [PCT_W-1:0] pct_t;

    // Which channel holds the maximum; ties go to red, then green.
    typedef enum logic [2:0] {
        SEC_RED   = 3'b001,
        SEC_GREEN = 3'b010,
        SEC_BLUE  = 3'b100
    } sector_t;

    // Everything the two dividers and the output stage need for one pixel.
    typedef struct packed {
        logic             valid;
        logic             grey;
        logic [NUM_W-1:0] sat_num;
        logic [DEN_W-1:0] sat_den;
        logic [NUM_W-1:0] hue_num;
        logic [DEN_W-1:0] hue_den;
        pct_t             lightness;
        chan_t            alpha;
    } front_t;

endpackage

/* design/rgb_to_hsl_converter.sv */
// RGB to HSL converter, top level.
// From the start transfer to the done strobe a pixel passes 3 front-end
// stages, 14 divider stages of one quotient bit each and 1 output register.
// Throughput: one pixel per cycle; busy is always low and results are never held.
// Reset (rst_n, asynchronous, active low) clears every valid bit; pixels in
// flight are dropped and no done strobe follows until a new start.
module rgb_to_hsl_converter (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  rhc_pkg::chan_t red_in,
    input  rhc_pkg::chan_t green_in,
    input  rhc_pkg::chan_t blue_in,
    input  rhc_pkg::chan_t alpha_in,
    output logic           done,
    output rhc_pkg::hue_t  hue_out,
    output rhc_pkg::pct_t  saturation_out,
    output rhc_pkg::pct_t  lightness_out,
    output rhc_pkg::chan_t alpha_out
);
    import rhc_pkg::*;

    // Every stage advances every cycle and the receiver takes each result in
    // the cycle it appears, so the pipeline never has to refuse a transfer.
    assign busy = 1'b0;

    logic   accept;
    front_t front;

    assign accept = start & ~busy;

    // Front end: max/min and sector, then spread and sum, then the exact
    // lightness and the dividend/divisor pairs for saturation and hue.
    rhc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .red_in   (red_in),
        .green_in (green_in),
        .blue_in  (blue_in),
        .alpha_in (alpha_in),
        .front    (front)
    );

    // Two dividers run in lock step. The saturation divider carries the
    // lightness alongside; the hue divider carries the grey flag and alpha.
    // On a grey pixel the divisors are meaningless, and the grey flag forces
    // both quotients to zero at the output.
    logic                 sat_valid, hue_valid;
    logic [QUO_W-1:0]     sat_quo, hue_quo;
    pct_t                 lig_side;
    logic [CH_W:0]        hue_side;

    rhc_div_pipe #(
        .NUM_W  (NUM_W),
        .DEN_W  (DEN_W),
        .QUO_W  (QUO_W),
        .SIDE_W (PCT_W)
    ) u_sat_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front.valid),
        .num       (front.sat_num),
        .den       (front.sat_den),
        .side_in   (front.lightness),
        .out_valid (sat_valid),
        .quo       (sat_quo),
        .side_out  (lig_side)
    );

    rhc_div_pipe #(
        .NUM_W  (NUM_W),
        .DEN_W  (DEN_W),
        .QUO_W  (QUO_W),
        .SIDE_W (CH_W + 1)
    ) u_hue_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front.valid),
        .num       (front.hue_num),
        .den       (front.hue_den),
        .side_in   ({front.grey, front.alpha}),
        .out_valid (hue_valid),
        .quo       (hue_quo),
        .side_out  (hue_side)
    );

    // Output stage: a hue that rounds up to a full turn wraps to zero, and a
    // grey pixel reports zero hue and saturation.
    logic           done_reg, done_next;
    hue_t           hue_reg, hue_next;
    pct_t           sat_reg, sat_next;
    pct_t           lig_reg;
    chan_t          alpha_reg;
    logic [QUO_W-1:0] hue_wrapped;

    always_comb
    begin
        done_next = sat_valid & hue_valid;
        if (hue_quo >= HUE_TURN)
        begin
            hue_wrapped = hue_quo - HUE_TURN;
        end
        else
        begin
            hue_wrapped = hue_quo;
        end
        if (hue_side[CH_W])
        begin
            hue_next = '0;
            sat_next = '0;
        end
        else
        begin
            hue_next = hue_wrapped[HUE_W-1:0];
            sat_next = sat_quo[PCT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hue_reg   <= hue_next;
        sat_reg   <= sat_next;
        lig_reg   <= lig_side;
        alpha_reg <= hue_side[CH_W-1:0];
    end

    assign done           = done_reg;
    assign hue_out        = hue_reg;
    assign saturation_out = sat_reg;
    assign lightness_out  = lig_reg;
    assign alpha_out      = alpha_reg;

endmodule

/* design/rhc_front.sv */
// Front end of the RGB to HSL converter: three register stages that find the
// extremes, the spread and sum, lightness and the two dividend/divisor pairs.
// Depends on rhc_pkg.
module rhc_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  rhc_pkg::chan_t red_in,
    input  rhc_pkg::chan_t green_in,
    input  rhc_pkg::chan_t blue_in,
    input  rhc_pkg::chan_t alpha_in,
    output rhc_pkg::front_t front
);
    import rhc_pkg::*;

    // Stage A: extremes, sector and the signed channel difference.
    logic        valid_a_reg;
    chan_t       max_a_reg, max_a_next;
    chan_t       min_a_reg, min_a_next;
    sector_t     sec_a_reg, sec_a_next;
    logic signed [CH_W:0] diff_a_reg, diff_a_next;
    chan_t       alpha_a_reg;

    // Stage B: spread, sum and saturation denominator.
    logic        valid_b_reg;
    chan_t       d_b_reg, d_b_next;
    logic [CH_W:0] s_b_reg, s_b_next;
    chan_t       den_b_reg, den_b_next;
    sector_t     sec_b_reg;
    logic signed [CH_W:0] diff_b_reg;
    chan_t       alpha_b_reg;

    // Stage C: the record handed to the dividers.
    logic        valid_c_reg;
    front_t      front_reg, front_next;

    always_comb
    begin
        if (red_in >= green_in && red_in >= blue_in)
        begin
            sec_a_next  = SEC_RED;
            max_a_next  = red_in;
            diff_a_next = $signed({1'b0, green_in}) - $signed({1'b0, blue_in});
        end
        else if (green_in >= blue_in)
        begin
            sec_a_next  = SEC_GREEN;
            max_a_next  = green_in;
            diff_a_next = $signed({1'b0, blue_in}) - $signed({1'b0, red_in});
        end
        else
        begin
            sec_a_next  = SEC_BLUE;
            max_a_next  = blue_in;
            diff_a_next = $signed({1'b0, red_in}) - $signed({1'b0, green_in});
        end
        min_a_next = red_in;
        if (green_in < min_a_next)
        begin
            min_a_next = green_in;
        end
        if (blue_in < min_a_next)
        begin
            min_a_next = blue_in;
        end
    end

    always_comb
    begin
        d_b_next = max_a_reg - min_a_reg;
        s_b_next = {1'b0, max_a_reg} + {1'b0, min_a_reg};
        if (s_b_next <= (CH_W+1)'(255))
        begin
            den_b_next = s_b_next[CH_W-1:0];
        end
        else
        begin
            den_b_next = CH_W'((CH_W+1)'(510) - s_b_next);
        end
    end

    // Lightness is floor((s*12800 + 255) / 510), split as 25*s plus
    // floor((50*s + 255) / 510); the small quotient is a divide by 255 of
    // half the value, done with the add-and-shift identity.
    logic [14:0]      lig_t;
    logic [13:0]      lig_y;
    logic [13:0]      lig_q;
    logic signed [24:0] diff_ext, prod, d_ext, offset, hue_sum;

    always_comb
    begin
        lig_t = 15'(s_b_reg) * 15'd50 + 15'd255;
        lig_y = lig_t[14:1];
        lig_q = 14'((lig_y + (lig_y >> 8) + 14'd1) >> 8);

        diff_ext = {{(25-CH_W-1){diff_b_reg[CH_W]}}, diff_b_reg};
        d_ext    = $signed({{(25-CH_W){1'b0}}, d_b_reg});
        prod     = diff_ext * 25'sd960;
        case (sec_b_reg)
            SEC_RED:   offset = diff_b_reg[CH_W] ? d_ext * 25'sd5760 : 25'sd0;
            SEC_GREEN: offset = d_ext * 25'sd1920;
            SEC_BLUE:  offset = d_ext * 25'sd3840;
            default:   offset = 25'sd0;
        endcase
        hue_sum = ((prod + offset) <<< 1) + d_ext;

        front_next.valid     = valid_b_reg;
        front_next.grey      = (d_b_reg == '0);
        front_next.sat_num   = NUM_W'(d_b_reg) * NUM_W'(25600) + NUM_W'(den_b_reg);
        front_next.sat_den   = {den_b_reg, 1'b0};
        front_next.hue_num   = hue_sum[NUM_W-1:0];
        front_next.hue_den   = {d_b_reg, 1'b0};
        front_next.lightness = PCT_W'(s_b_reg) * PCT_W'(25) + lig_q;
        front_next.alpha     = alpha_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        max_a_reg   <= max_a_next;
        min_a_reg   <= min_a_next;
        sec_a_reg   <= sec_a_next;
        diff_a_reg  <= diff_a_next;
        alpha_a_reg <= alpha_in;

        d_b_reg     <= d_b_next;
        s_b_reg     <= s_b_next;
        den_b_reg   <= den_b_next;
        sec_b_reg   <= sec_a_reg;
        diff_b_reg  <= diff_a_reg;
        alpha_b_reg <= alpha_a_reg;

        front_reg   <= front_next;
    end

    always_comb
    begin
        front       = front_reg;
        front.valid = valid_c_reg;
    end

endmodule

/* design/rhc_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per register stage, with a
// sideband word that travels alongside the operands.
// Depends on nothing; widths come from its parameters.
module rhc_div_pipe #(
    parameter int NUM_W  = 23,
    parameter int DEN_W  = 9,
    parameter int QUO_W  = 14,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quo,
    output logic [SIDE_W-1:0] side_out
);
    // The quotient must fit in QUO_W bits; the remainder never exceeds the
    // dividend, and the divisor is shifted up to QUO_W-1 places.
    localparam int REM_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic              valid_reg [QUO_W];
    logic [REM_W-1:0]  rem_reg   [QUO_W];
    logic [QUO_W-1:0]  quo_reg   [QUO_W];
    logic [DEN_W-1:0]  den_reg   [QUO_W];
    logic [SIDE_W-1:0] side_reg  [QUO_W];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        localparam int BIT = QUO_W - 1 - k;

        logic              valid_cur;
        logic [REM_W-1:0]  rem_cur, rem_next, den_sh;
        logic [QUO_W-1:0]  quo_cur, quo_next;
        logic [DEN_W-1:0]  den_cur;
        logic [SIDE_W-1:0] side_cur;

        if (k == 0)
        begin : g_first
            assign valid_cur = in_valid;
            assign rem_cur   = REM_W'(num);
            assign quo_cur   = '0;
            assign den_cur   = den;
            assign side_cur  = side_in;
        end
        else
        begin : g_rest
            assign valid_cur = valid_reg[k-1];
            assign rem_cur   = rem_reg[k-1];
            assign quo_cur   = quo_reg[k-1];
            assign den_cur   = den_reg[k-1];
            assign side_cur  = side_reg[k-1];
        end

        always_comb
        begin
            den_sh   = REM_W'(den_cur) << BIT;
            quo_next = quo_cur;
            rem_next = rem_cur;
            if (rem_cur >= den_sh)
            begin
                rem_next      = rem_cur - den_sh;
                quo_next[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            quo_reg[k]  <= quo_next;
            den_reg[k]  <= den_cur;
            side_reg[k] <= side_cur;
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign quo       = quo_reg[QUO_W-1];
    assign side_out  = side_reg[QUO_W-1];

endmodule

/* tb/rgb_to_hsl_converter_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the RGB to HSL pixel converter.
// Depends on rhc_pkg and rgb_to_hsl_converter from the design folder.
module rgb_to_hsl_converter_tb;

    import rhc_pkg::*;

    // One converted pixel as it leaves the block.
    typedef struct packed {
        hue_t  hue;
        pct_t  saturation;
        pct_t  lightness;
        chan_t alpha;
    } hsl_t;

    // A directed stimulus row. Where the answer is obvious from the color
    // itself (black, white, primaries, secondaries, grey) it is typed in;
    // all other rows are checked against the predictor.
    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        chan_t alpha;
        bit    typed;
        hsl_t  want;
    } pixel_row_t;

    localparam int NUM_ROWS        = 21;
    localparam int RANDOM_PIXELS   = 430;
    localparam int NUM_PHASES      = 4;
    // Cycles to keep running at the end once every expected result has arrived.
    localparam int DRAIN_CYCLES    = 40;
    // No transfer in either direction for this long means the block is hung.
    localparam int WATCHDOG_CYCLES = 1000;

    localparam pixel_row_t PIXEL_ROWS [NUM_ROWS] = '{
        // Black and white: grey pixels, lightness at its extremes.
        '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, '{13'd0,    14'd0,     14'd0,     8'd0}},
        '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1, '{13'd0,    14'd0,     14'd12800, 8'd255}},
        // Pure primaries land on 0, 120 and 240 degrees.
        '{8'd255, 8'd0,   8'd0,   8'd255, 1'b1, '{13'd0,    14'd12800, 14'd6400,  8'd255}},
        '{8'd0,   8'd255, 8'd0,   8'd170, 1'b1, '{13'd1920, 14'd12800, 14'd6400,  8'd170}},
        '{8'd0,   8'd0,   8'd255, 8'd85,  1'b1, '{13'd3840, 14'd12800, 14'd6400,  8'd85}},
        // Secondaries exercise the channel ties: red beats green, green beats
        // blue, red beats blue (with a negative hue that wraps to 300 degrees).
        '{8'd255, 8'd255, 8'd0,   8'd255, 1'b1, '{13'd960,  14'd12800, 14'd6400,  8'd255}},
        '{8'd0,   8'd255, 8'd255, 8'd0,   1'b1, '{13'd2880, 14'd12800, 14'd6400,  8'd0}},
        '{8'd255, 8'd0,   8'd255, 8'd255, 1'b1, '{13'd4800, 14'd12800, 14'd6400,  8'd255}},
        // Mid grey rounds lightness down.
        '{8'd128, 8'd128, 8'd128, 8'd1,   1'b1, '{13'd0,    14'd0,     14'd6425,  8'd1}},
        // Near-grey, near-extreme and mid-range pixels, checked against the predictor.
        '{8'd1,   8'd0,   8'd0,   8'd254, 1'b0, '0},
        '{8'd0,   8'd0,   8'd1,   8'd128, 1'b0, '0},
        '{8'd255, 8'd254, 8'd255, 8'd127, 1'b0, '0},
        '{8'd254, 8'd255, 8'd255, 8'd64,  1'b0, '0},
        '{8'd170, 8'd85,  8'd0,   8'd170, 1'b0, '0},
        '{8'd85,  8'd170, 8'd255, 8'd85,  1'b0, '0},
        '{8'd255, 8'd128, 8'd0,   8'd32,  1'b0, '0},
        // Red maximum with blue just above green: hue just under a full turn.
        '{8'd254, 8'd0,   8'd1,   8'd16,  1'b0, '0},
        '{8'd1,   8'd2,   8'd3,   8'd8,   1'b0, '0},
        '{8'd200, 8'd100, 8'd150, 8'd4,   1'b0, '0},
        '{8'd10,  8'd200, 8'd100, 8'd2,   1'b0, '0},
        '{8'd127, 8'd128, 8'd129, 8'd129, 1'b0, '0}
    };

    // Percent chance that the source sits idle before each pixel, per phase.
    // The result side cannot stall, so only the source idles here.
    localparam int PHASE_IDLE_PCT [NUM_PHASES] = '{0, 54, 0, 31};

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    chan_t red_in;
    chan_t green_in;
    chan_t blue_in;
    chan_t alpha_in;
    logic  done;
    hue_t  hue_out;
    pct_t  saturation_out;
    pct_t  lightness_out;
    chan_t alpha_out;

    hsl_t expected_hsl [$];
    int   mismatch_count;
    int   source_idle_pct;
    int   quiet_cycles;

    rgb_to_hsl_converter i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .red_in         (red_in),
        .green_in       (green_in),
        .blue_in        (blue_in),
        .alpha_in       (alpha_in),
        .done           (done),
        .hue_out        (hue_out),
        .saturation_out (saturation_out),
        .lightness_out  (lightness_out),
        .alpha_out      (alpha_out)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Exact integer conversion of one pixel. Every quotient below has a
    // non-negative dividend, so integer division is a floor, and adding half
    // the divisor first gives rounding half up.
    function automatic hsl_t predict_hsl(input chan_t red, input chan_t green,
                                         input chan_t blue, input chan_t alpha);
        int      r;
        int      g;
        int      b;
        int      hi;
        int      lo;
        int      spread;
        int      sum;
        int      den;
        int      num;
        int      hue;
        sector_t sector;
        hsl_t    hsl;
        begin
            r = red;
            g = green;
            b = blue;
            // The channel that holds the maximum; ties go to red, then green.
            if (r >= g && r >= b)
                sector = SEC_RED;
            else if (g >= b)
                sector = SEC_GREEN;
            else
                sector = SEC_BLUE;
            hi = (r > g) ? r : g;
            hi = (b > hi) ? b : hi;
            lo = (r < g) ? r : g;
            lo = (b < lo) ? b : lo;
            spread = hi - lo;
            sum    = hi + lo;

            hsl.alpha      = alpha;
            hsl.lightness  = pct_t'((sum * 25600 + 510) / 1020);
            hsl.hue        = '0;
            hsl.saturation = '0;
            if (spread != 0)
            begin
                // The divisor is 255 - |sum - 255|, never smaller than the spread.
                den = (sum <= 255) ? sum : 510 - sum;
                hsl.saturation = pct_t'((spread * 25600 + den) / (2 * den));
                // The hue numerator is in 1/16 degree, scaled by the spread.
                case (sector)
                    SEC_RED:
                    begin
                        num = 960 * (g - b);
                        if (num < 0)
                            num += 5760 * spread;
                    end
                    SEC_GREEN: num = 960 * (b - r) + 1920 * spread;
                    default:   num = 960 * (r - g) + 3840 * spread;
                endcase
                hue = (2 * num + spread) / (2 * spread);
                // Rounding up to a full turn wraps back to zero.
                if (hue >= 5760)
                    hue -= 5760;
                hsl.hue = hue_t'(hue);
            end
            return hsl;
        end
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        begin
            $display("%0t: %s mismatch: got %0d, expected %0d", $time, field, got, want);
            mismatch_count++;
        end
    endtask

    // Offers one pixel, idling first at the current rate, and records the
    // expected result once the transfer has happened.
    task automatic send_pixel(input chan_t red, input chan_t green, input chan_t blue,
                              input chan_t alpha, input hsl_t want);
        begin
            while ($urandom_range(99) < source_idle_pct)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
            start    <= 1'b1;
            red_in   <= red;
            green_in <= green;
            blue_in  <= blue;
            alpha_in <= alpha;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            expected_hsl.push_back(want);
        end
    endtask

    // Random pixel with a bias toward the interesting corners: channel ties,
    // grey, near-grey colors and channels pinned at their extremes.
    task automatic send_random_pixel();
        chan_t red;
        chan_t green;
        chan_t blue;
        chan_t alpha;
        chan_t base;
        int    mode;
        begin
            red   = chan_t'($urandom);
            green = chan_t'($urandom);
            blue  = chan_t'($urandom);
            alpha = chan_t'($urandom);
            base  = chan_t'($urandom);
            mode  = $urandom_range(9);
            case (mode)
                5:
                begin
                    // Two channels tie, in a random pair.
                    case ($urandom_range(2))
                        0: green = red;
                        1: blue = red;
                        default: blue = green;
                    endcase
                end
                6:
                begin
                    // Two channels tie at the maximum.
                    base  = chan_t'($urandom_range(255, 128));
                    red   = base;
                    green = base;
                    blue  = base;
                    case ($urandom_range(2))
                        0: red = chan_t'($urandom_range(base));
                        1: green = chan_t'($urandom_range(base));
                        default: blue = chan_t'($urandom_range(base));
                    endcase
                end
                7:
                begin
                    red   = base;
                    green = base;
                    blue  = base;
                end
                8:
                begin
                    // Channels within a few steps of each other.
                    base  = chan_t'($urandom_range(251, 2));
                    red   = chan_t'(int'(base) + $urandom_range(4) - 2);
                    green = chan_t'(int'(base) + $urandom_range(4) - 2);
                    blue  = chan_t'(int'(base) + $urandom_range(4) - 2);
                end
                9:
                begin
                    red   = $urandom_range(1) ? 8'd255 - chan_t'($urandom_range(1))
                                              : chan_t'($urandom_range(1));
                    green = $urandom_range(1) ? 8'd255 - chan_t'($urandom_range(1))
                                              : chan_t'($urandom_range(1));
                    blue  = $urandom_range(1) ? 8'd255 - chan_t'($urandom_range(1))
                                              : chan_t'($urandom_range(1));
                end
                default:
                begin
                end
            endcase
            send_pixel(red, green, blue, alpha, predict_hsl(red, green, blue, alpha));
        end
    endtask

    // Stimulus: reset, the directed rows, then random pixels in phases with
    // different idle rates, and finally a drain of the pipeline.
    initial
    begin : stimulus
        hsl_t want;
        rst_n           <= 1'b0;
        start           <= 1'b0;
        red_in          <= '0;
        green_in        <= '0;
        blue_in         <= '0;
        alpha_in        <= '0;
        mismatch_count  = 0;
        source_idle_pct = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int row = 0; row < NUM_ROWS; row++)
        begin
            if (PIXEL_ROWS[row].typed)
                want = PIXEL_ROWS[row].want;
            else
                want = predict_hsl(PIXEL_ROWS[row].red, PIXEL_ROWS[row].green,
                                   PIXEL_ROWS[row].blue, PIXEL_ROWS[row].alpha);
            send_pixel(PIXEL_ROWS[row].red, PIXEL_ROWS[row].green,
                       PIXEL_ROWS[row].blue, PIXEL_ROWS[row].alpha, want);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            source_idle_pct = PHASE_IDLE_PCT[phase];
            for (int n = 0; n < RANDOM_PIXELS / NUM_PHASES; n++)
                send_random_pixel();
        end

        start <= 1'b0;
        while (expected_hsl.size() != 0)
            @(posedge clk);
        // Any stray result arriving after the last expected one is caught here.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Result checker. Outputs are sampled at the edge that ends the strobe
    // cycle, so the values seen are the ones held during that cycle.
    always @(posedge clk)
    begin : result_check
        hsl_t want;
        if (rst_n && done)
        begin
            if (expected_hsl.size() == 0)
            begin
                $display("%0t: result transfer with no pixel outstanding", $time);
                mismatch_count++;
            end
            else
            begin
                want = expected_hsl.pop_front();
                if (hue_out !== want.hue)
                    report_mismatch("hue_out", hue_out, want.hue);
                if (saturation_out !== want.saturation)
                    report_mismatch("saturation_out", saturation_out, want.saturation);
                if (lightness_out !== want.lightness)
                    report_mismatch("lightness_out", lightness_out, want.lightness);
                if (alpha_out !== want.alpha)
                    report_mismatch("alpha_out", alpha_out, want.alpha);
            end
        end
    end

    // Watchdog: counts cycles with neither an input nor a result transfer.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_CYCLES);
            $display("FAIL");
            $finish;
        end
    end

endmodule

/* sim.f */
design/rhc_pkg.sv
design/rhc_front.sv
design/rhc_div_pipe.sv
design/rgb_to_hsl_converter.sv
tb/rgb_to_hsl_converter_tb.sv
